// File: sv/lcvfb_pkg.sv
// lcvfb_pkg: shared types, codes and frame remapping functions for the
// led cube voxel frame buffer; no dependencies
`default_nettype none

package lcvfb_pkg;

   localparam int FrameBits = 64;
   localparam int ReqWidth  = 32;
   localparam int RspWidth  = 16;

   typedef enum logic [2:0] {
      CMD_WRITE   = 3'd0,
      CMD_READ    = 3'd1,
      CMD_SHIFT   = 3'd2,
      CMD_ALL_OFF = 3'd3,
      CMD_ALL_ON  = 3'd4,
      CMD_LOAD    = 3'd5,
      CMD_PUSH    = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   localparam logic KIND_READ    = 1'b0;
   localparam logic KIND_DISPLAY = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_PUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       apply;       // accepted word, update the frame
      logic       load_read;   // load a read answer into the output stage
      logic       load_push;   // load one display write into the output stage
      logic [2:0] digit;       // display digit index, 0 based
      logic       last_digit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // bit of the flat frame for zero based x, y, z
   function automatic logic [5:0] voxel_idx(logic [1:0] x, logic [1:0] y, logic [1:0] z);
      return {z[1], y, ~z[0], ~x};
   endfunction

   function automatic logic coord_ok(logic [2:0] v);
      return (v != 3'd0) && (v <= 3'd4);
   endfunction

   // one step shift with drop-out, invalid axis clears
   function automatic logic [FrameBits-1:0] shift_frame(logic [FrameBits-1:0] f,
                                                        logic [1:0] ax, logic up);
      logic [FrameBits-1:0] nf;
      int sx;
      int sy;
      int sz;
      int d;
      nf = '0;
      d  = up ? -1 : 1;
      if (ax != AXIS_NONE) begin
         for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 4; y++) begin
               for (int z = 0; z < 4; z++) begin
                  sx = x;
                  sy = y;
                  sz = z;
                  if (ax == AXIS_X) sx = x + d;
                  else if (ax == AXIS_Y) sy = y + d;
                  else sz = z + d;
                  if (sx >= 0 && sx <= 3 && sy >= 0 && sy <= 3 && sz >= 0 && sz <= 3)
                     nf[voxel_idx(2'(x), 2'(y), 2'(z))] =
                        f[voxel_idx(2'(sx), 2'(sy), 2'(sz))];
               end
            end
         end
      end
      return nf;
   endfunction

   // frame to display digit registers, byte d is digit d+1
   function automatic logic [FrameBits-1:0] map_display(logic [FrameBits-1:0] f);
      logic [FrameBits-1:0] m;
      int dig;
      int seg;
      m = '0;
      for (int x = 0; x < 4; x++) begin
         for (int y = 0; y < 4; y++) begin
            for (int z = 0; z < 4; z++) begin
               dig = (x < 2) ? z : z + 4;
               seg = (x == 0 || x == 3) ? 7 - y : 3 - y;
               m[dig*8 + seg] = f[voxel_idx(2'(x), 2'(y), 2'(z))];
            end
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: sv/led_cube_voxel_frame_buffer_unit.sv
// latency: a read answer shows on rsp the cycle after its word is accepted
// throughput: write, shift, all off, all on, load and read words are accepted one per
// cycle while the output stage is free; a push accepts its word, then sends eight display
// writes from the single output stage, one per cycle unless rsp_tready stalls
// reset: synchronous, clears the whole frame (all voxels off) and the sequencer
// top level: joins lcvfb_ctrl and lcvfb_dp; depends on lcvfb_pkg
`default_nettype none

module led_cube_voxel_frame_buffer_unit import lcvfb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   // command words
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // command[2:0], x_pos[5:3], y_pos[8:6], z_pos[11:9], voxel_on[12],
   // axis[14:13], toward_higher[15], row_index[18:16], row_data[26:19], zero fill
   input  wire logic [ReqWidth-1:0] req_tdata,
   // result words
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // voxel_value[0], digit_address[4:1], segment_data[12:5], zero fill
   output logic [RspWidth-1:0]      rsp_tdata,
   // last: read answer or eighth display write
   output logic                     rsp_tlast,
   // kind[0]: 0 read answer, 1 display register write
   output logic                     rsp_tuser
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer: accepts a word when the output stage is free, runs push digits
   lcvfb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tdata[2:0]),
      .status      (status),
      .cmd         (cmd)
   );

   // frame register, shift and display remap, registered result stage
   lcvfb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: sv/lcvfb_ctrl.sv
// lcvfb_ctrl: command sequencer, accepts words and steps through the
// eight display writes of a push; depends on lcvfb_pkg
`default_nettype none

module lcvfb_ctrl import lcvfb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [2:0]    req_command,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_tready     = 1'b0;
      accept         = 1'b0;
      cmd            = '0;
      cmd.digit      = cnt_ff;
      cmd.last_digit = (cnt_ff == 3'd7);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            accept     = req_tvalid && status.out_free;
            cmd.apply  = accept;
            if (accept && req_command == CMD_READ)
               cmd.load_read = 1'b1;
            if (accept && req_command == CMD_PUSH) begin
               state_in = ST_PUSH;
               cnt_in   = 3'd0;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.load_push = 1'b1;
               cnt_in        = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_read && cmd.load_push))
      else $error("read and push loaded together");

   a_push_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_PUSH) |=> (state_ff == ST_PUSH && cnt_ff == 3'd0))
      else $error("push did not start at digit one");

   a_push_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_push && cnt_ff == 3'd7) |=> (state_ff == ST_IDLE))
      else $error("push did not end after eighth write");

endmodule

`default_nettype wire

// File: sv/lcvfb_dp.sv
// lcvfb_dp: voxel frame register, command execution and result output
// stage; depends on lcvfb_pkg
`default_nettype none

module lcvfb_dp import lcvfb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [ReqWidth-1:0] req_tdata,
   input  wire ctl_cmd_type         cmd,
   output dp_status_type            status,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspWidth-1:0]      rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   logic [FrameBits-1:0] frame_ff, frame_in;
   logic                 valid_ff, valid_in;
   logic                 kind_ff, kind_in;
   logic                 voxel_ff, voxel_in;
   logic [3:0]           digit_ff, digit_in;
   logic [7:0]           seg_ff, seg_in;
   logic                 last_ff, last_in;

   logic [2:0]           f_cmd, f_x, f_y, f_z, f_row;
   logic                 f_on, f_up;
   logic [1:0]           f_axis;
   logic [7:0]           f_data;
   logic                 in_range;
   logic [5:0]           idx;
   logic [2:0]           x_m1, y_m1, z_m1;
   logic [FrameBits-1:0] shifted, mapped;

   assign f_cmd  = req_tdata[2:0];
   assign f_x    = req_tdata[5:3];
   assign f_y    = req_tdata[8:6];
   assign f_z    = req_tdata[11:9];
   assign f_on   = req_tdata[12];
   assign f_axis = req_tdata[14:13];
   assign f_up   = req_tdata[15];
   assign f_row  = req_tdata[18:16];
   assign f_data = req_tdata[26:19];

   assign x_m1     = f_x - 3'd1;
   assign y_m1     = f_y - 3'd1;
   assign z_m1     = f_z - 3'd1;
   assign in_range = coord_ok(f_x) && coord_ok(f_y) && coord_ok(f_z);
   assign idx      = voxel_idx(x_m1[1:0], y_m1[1:0], z_m1[1:0]);

   assign shifted = shift_frame(frame_ff, f_axis, f_up);
   assign mapped  = map_display(frame_ff);

   assign status.out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         valid_ff <= valid_in;
      end
      kind_ff  <= kind_in;
      voxel_ff <= voxel_in;
      digit_ff <= digit_in;
      seg_ff   <= seg_in;
      last_ff  <= last_in;
   end

   always_comb begin
      frame_in = frame_ff;
      if (cmd.apply) begin
         unique case (f_cmd)
            CMD_WRITE:   if (in_range) frame_in[idx] = f_on;
            CMD_SHIFT:   frame_in = shifted;
            CMD_ALL_OFF: frame_in = '0;
            CMD_ALL_ON:  frame_in = '1;
            CMD_LOAD:    frame_in[f_row*8 +: 8] = f_data;
            default:     frame_in = frame_ff;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      voxel_in = voxel_ff;
      digit_in = digit_ff;
      seg_in   = seg_ff;
      last_in  = last_ff;
      if (cmd.load_read) begin
         valid_in = 1'b1;
         kind_in  = KIND_READ;
         voxel_in = in_range && frame_ff[idx];
         digit_in = 4'd0;
         seg_in   = 8'd0;
         last_in  = 1'b1;
      end else if (cmd.load_push) begin
         valid_in = 1'b1;
         kind_in  = KIND_DISPLAY;
         voxel_in = 1'b0;
         digit_in = {1'b0, cmd.digit} + 4'd1;
         seg_in   = mapped[cmd.digit*8 +: 8];
         last_in  = cmd.last_digit;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, seg_ff, digit_ff, voxel_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_read || cmd.load_push) |-> status.out_free)
      else $error("output stage overwritten");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (frame_ff == '0 && !valid_ff))
      else $error("frame not cleared by reset");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// tb_top: self-checking bench for led_cube_voxel_frame_buffer_unit, with a bit-exact
// frame predictor, random stream traffic with stalls on both sides and a result checker
// depends on lcvfb_pkg and led_cube_voxel_frame_buffer_unit
`default_nettype none

module tb_top;
   import lcvfb_pkg::*;

   // command 7 has no name in the package, the block must ignore it
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   // cycles with no word moving on either side before the run is declared hung
   localparam int IdleLimit = 1500;
   // cap on printed mismatch lines, failures are still counted
   localparam int MaxReports = 40;

   // store byte b holds bits [b*8 +: 8] of the frame
   typedef logic [7:0][7:0] cube_frame_type;

   typedef struct {
      logic [2:0] command;
      logic [2:0] x_pos;
      logic [2:0] y_pos;
      logic [2:0] z_pos;
      logic       voxel_on;
      logic [1:0] axis;
      logic       toward_higher;
      logic [2:0] row_index;
      logic [7:0] row_data;
   } cube_cmd_type;

   typedef struct {
      logic       kind;
      logic       voxel_value;
      logic [3:0] digit_address;
      logic [7:0] segment_data;
      logic       last;
   } cube_answer_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;

   // predicted frame contents and the answers still owed by the block
   cube_frame_type  cube_model = '0;
   cube_answer_type pending_answers[$];

   // knobs for the traffic shape
   bit req_gaps_on     = 1'b0;
   bit rsp_stalls_on   = 1'b0;
   int hold_off_cycles = 0;

   int error_count    = 0;
   int words_sent     = 0;
   int reads_checked  = 0;
   int digits_checked = 0;
   int idle_cycles    = 0;

   led_cube_voxel_frame_buffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // command[2:0], x_pos[5:3], y_pos[8:6], z_pos[11:9], voxel_on[12],
      // axis[14:13], toward_higher[15], row_index[18:16], row_data[26:19], zero fill
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // voxel_value[0], digit_address[4:1], segment_data[12:5], zero fill
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      // kind[0]: 0 read answer, 1 display register write
      .rsp_tuser  (rsp_tuser)
   );

   // 12 unit clock period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // frame predictor
   // ---------------------------------------------------------------

   function automatic bit in_cube(logic [2:0] v);
      return v >= 3'd1 && v <= 3'd4;
   endfunction

   // layers 1,2 share bytes 0..3, layers 3,4 share bytes 4..7
   function automatic int store_byte(int y, int z);
      return (z <= 2) ? y - 1 : y + 3;
   endfunction

   // odd layers sit in the upper nibble, even layers in the lower one
   function automatic int store_bit(int x, int z);
      return (z % 2 == 1) ? 8 - x : 4 - x;
   endfunction

   function automatic logic voxel_lit(cube_frame_type f, int x, int y, int z);
      return f[store_byte(y, z)][store_bit(x, z)];
   endfunction

   // move every lit voxel one step, whatever crosses an edge drops out
   function automatic cube_frame_type shifted_frame(cube_frame_type f, logic [1:0] ax,
                                                    logic up);
      cube_frame_type nf;
      int pos[3];
      nf = '0;
      if (ax != AXIS_NONE) begin
         for (int x = 1; x <= 4; x++) begin
            for (int y = 1; y <= 4; y++) begin
               for (int z = 1; z <= 4; z++) begin
                  if (voxel_lit(f, x, y, z)) begin
                     pos[0] = x;
                     pos[1] = y;
                     pos[2] = z;
                     pos[ax] = up ? pos[ax] + 1 : pos[ax] - 1;
                     if (pos[ax] >= 1 && pos[ax] <= 4)
                        nf[store_byte(pos[1], pos[2])][store_bit(pos[0], pos[2])] = 1'b1;
                  end
               end
            end
         end
      end
      return nf;
   endfunction

   // byte d of the result is what digit register d+1 receives
   function automatic cube_frame_type display_digits(cube_frame_type f);
      cube_frame_type m;
      int dig;
      int seg;
      m = '0;
      for (int x = 1; x <= 4; x++) begin
         for (int y = 1; y <= 4; y++) begin
            for (int z = 1; z <= 4; z++) begin
               dig = (x <= 2) ? z - 1 : z + 3;
               seg = (x == 1 || x == 4) ? 8 - y : 4 - y;
               if (voxel_lit(f, x, y, z))
                  m[dig][seg] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   // apply one accepted word to the model and queue what it should produce
   task automatic predict_word(cube_cmd_type c);
      cube_answer_type ans;
      cube_frame_type  digits;
      bit              ok;
      ok = in_cube(c.x_pos) && in_cube(c.y_pos) && in_cube(c.z_pos);
      case (c.command)
         CMD_WRITE: begin
            if (ok)
               cube_model[store_byte(c.y_pos, c.z_pos)][store_bit(c.x_pos, c.z_pos)] =
                  c.voxel_on;
         end
         CMD_READ: begin
            ans.kind          = KIND_READ;
            ans.voxel_value   = ok ? voxel_lit(cube_model, c.x_pos, c.y_pos, c.z_pos) : 1'b0;
            ans.digit_address = 4'd0;
            ans.segment_data  = 8'd0;
            ans.last          = 1'b1;
            pending_answers.push_back(ans);
         end
         CMD_SHIFT:   cube_model = shifted_frame(cube_model, c.axis, c.toward_higher);
         CMD_ALL_OFF: cube_model = '0;
         CMD_ALL_ON:  cube_model = '1;
         CMD_LOAD:    cube_model[c.row_index] = c.row_data;
         CMD_PUSH: begin
            digits = display_digits(cube_model);
            for (int d = 0; d < 8; d++) begin
               ans.kind          = KIND_DISPLAY;
               ans.voxel_value   = 1'b0;
               ans.digit_address = 4'(d + 1);
               ans.segment_data  = digits[d];
               ans.last          = (d == 7);
               pending_answers.push_back(ans);
            end
         end
         default: ;   // unused code, no effect
      endcase
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic cube_cmd_type voxel_cmd(logic [2:0] cmd, logic [2:0] x, logic [2:0] y,
                                              logic [2:0] z, logic on);
      cube_cmd_type c;
      c = '{default: '0};
      c.command  = cmd;
      c.x_pos    = x;
      c.y_pos    = y;
      c.z_pos    = z;
      c.voxel_on = on;
      return c;
   endfunction

   function automatic cube_cmd_type frame_cmd(logic [2:0] cmd, logic [1:0] ax, logic up,
                                              logic [2:0] row, logic [7:0] data);
      cube_cmd_type c;
      c = '{default: '0};
      c.command       = cmd;
      c.axis          = ax;
      c.toward_higher = up;
      c.row_index     = row;
      c.row_data      = data;
      return c;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 6);
      return $urandom_range(12, 40);
   endfunction

   // coordinates mostly inside the cube, the rest anywhere in the field
   function automatic logic [2:0] rand_coord();
      if ($urandom_range(0, 99) < 88) return 3'($urandom_range(1, 4));
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic cube_cmd_type random_cmd();
      cube_cmd_type c;
      int r;
      r = $urandom_range(0, 99);
      // unused fields carry random noise
      c.x_pos         = rand_coord();
      c.y_pos         = rand_coord();
      c.z_pos         = rand_coord();
      c.voxel_on      = 1'($urandom);
      c.axis          = ($urandom_range(0, 99) < 8) ? AXIS_NONE : 2'($urandom_range(0, 2));
      c.toward_higher = 1'($urandom);
      c.row_index     = 3'($urandom);
      c.row_data      = 8'($urandom);
      if (r < 28)      c.command = CMD_WRITE;
      else if (r < 52) c.command = CMD_READ;
      else if (r < 64) c.command = CMD_SHIFT;
      else if (r < 67) c.command = CMD_ALL_OFF;
      else if (r < 69) c.command = CMD_ALL_ON;
      else if (r < 83) c.command = CMD_LOAD;
      else if (r < 97) c.command = CMD_PUSH;
      else             c.command = CMD_UNUSED;
      return c;
   endfunction

   // offer one command word, predict on acceptance, then maybe idle;
   // tvalid stays high when no gap follows, so the next call must send at once
   task automatic send_word(cube_cmd_type c);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, c.row_data, c.row_index, c.toward_higher, c.axis, c.voxel_on,
                     c.z_pos, c.y_pos, c.x_pos, c.command};
      do @(posedge clock); while (!req_tready);
      predict_word(c);
      words_sent++;
      gap = (req_gaps_on && $urandom_range(0, 1)) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every owed answer come back
   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls, long hold-off on request
   // ---------------------------------------------------------------

   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            rsp_tready <= 1'b0;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(string what, int want, int got);
      error_count++;
      if (error_count <= MaxReports)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
   endtask

   // compare every result word with the oldest answer owed
   always @(posedge clock) begin : rsp_checker
      cube_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            if (error_count <= MaxReports)
               $display("%0t: unexpected result word, expected none, actual %0h last %0b kind %0b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", want.kind, rsp_tuser);
            if (rsp_tdata[0] !== want.voxel_value)
               report_mismatch("voxel_value", want.voxel_value, rsp_tdata[0]);
            if (rsp_tdata[4:1] !== want.digit_address)
               report_mismatch("digit_address", want.digit_address, rsp_tdata[4:1]);
            if (rsp_tdata[12:5] !== want.segment_data)
               report_mismatch("segment_data", want.segment_data, rsp_tdata[12:5]);
            if (rsp_tlast !== want.last)
               report_mismatch("last", want.last, rsp_tlast);
            if (want.kind == KIND_READ) reads_checked++;
            else digits_checked++;
         end
      end
   end

   // hang detector: counts cycles in which no word moves on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("timeout after %0d idle cycles, %0d answers outstanding", idle_cycles,
                  pending_answers.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // single voxel writes and reads at the cube corners and inside, bad coordinates ignored, then a push
   task automatic test_voxel_access();
      send_word(voxel_cmd(CMD_WRITE, 3'd1, 3'd1, 3'd1, 1'b1));
      send_word(voxel_cmd(CMD_WRITE, 3'd4, 3'd4, 3'd4, 1'b1));
      send_word(voxel_cmd(CMD_WRITE, 3'd2, 3'd3, 3'd2, 1'b1));
      send_word(voxel_cmd(CMD_WRITE, 3'd3, 3'd2, 3'd3, 1'b1));
      send_word(voxel_cmd(CMD_READ,  3'd1, 3'd1, 3'd1, 1'b0));
      send_word(voxel_cmd(CMD_READ,  3'd4, 3'd4, 3'd4, 1'b0));
      // zero and above-four coordinates must not touch the frame
      send_word(voxel_cmd(CMD_WRITE, 3'd0, 3'd2, 3'd2, 1'b1));
      send_word(voxel_cmd(CMD_WRITE, 3'd3, 3'd7, 3'd5, 1'b1));
      send_word(voxel_cmd(CMD_READ,  3'd0, 3'd2, 3'd2, 1'b0));
      send_word(voxel_cmd(CMD_READ,  3'd3, 3'd3, 3'd7, 1'b0));
      send_word(voxel_cmd(CMD_WRITE, 3'd4, 3'd4, 3'd4, 1'b0));
      send_word(voxel_cmd(CMD_READ,  3'd4, 3'd4, 3'd4, 1'b0));
      send_word(frame_cmd(CMD_PUSH, AXIS_X, 1'b0, 3'd0, 8'd0));
   endtask

   // whole-frame commands: load, shifts both ways on each axis, fill, clear, unused code
   task automatic test_frame_commands();
      send_word(frame_cmd(CMD_LOAD,  AXIS_X, 1'b0, 3'd0, 8'hA5));
      send_word(frame_cmd(CMD_LOAD,  AXIS_X, 1'b0, 3'd7, 8'hFF));
      send_word(frame_cmd(CMD_SHIFT, AXIS_X, 1'b1, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_SHIFT, AXIS_Y, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_SHIFT, AXIS_Z, 1'b1, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_PUSH,  AXIS_X, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_ALL_ON, AXIS_X, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_SHIFT, AXIS_Z, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_SHIFT, AXIS_Y, 1'b1, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_SHIFT, AXIS_X, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_PUSH,  AXIS_X, 1'b0, 3'd0, 8'd0));
      // invalid axis wipes the frame, unused code leaves it alone
      send_word(frame_cmd(CMD_SHIFT, AXIS_NONE, 1'b1, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_LOAD,  AXIS_X, 1'b0, 3'd3, 8'h5A));
      send_word(frame_cmd(CMD_UNUSED, AXIS_X, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_PUSH,  AXIS_X, 1'b0, 3'd0, 8'd0));
      send_word(frame_cmd(CMD_ALL_OFF, AXIS_X, 1'b0, 3'd0, 8'd0));
   endtask

   // random command mix; a write is often followed by a read of the same voxel
   task automatic test_random_traffic(int count);
      cube_cmd_type c;
      int n;
      n = 0;
      while (n < count) begin
         c = random_cmd();
         send_word(c);
         n++;
         if (c.command == CMD_WRITE && $urandom_range(0, 99) < 40) begin
            c.command = CMD_READ;
            send_word(c);
            n++;
         end
      end
   endtask

   // receiver holds off for a long stretch while pushes keep coming,
   // so the output stage fills and the block stops taking words
   task automatic test_output_backpressure();
      hold_off_cycles = 90;
      for (int i = 0; i < 6; i++) begin
         send_word(voxel_cmd(CMD_WRITE, rand_coord(), rand_coord(), rand_coord(), 1'b1));
         send_word(frame_cmd(CMD_PUSH, AXIS_X, 1'b0, 3'd0, 8'd0));
      end
   endtask

   // sender stops until every answer is back, then resumes
   task automatic test_drain_pause();
      test_random_traffic(15);
      wait_all_answered();
      test_random_traffic(15);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs with no idling at all
      test_voxel_access();
      test_frame_commands();

      // random part: first with idling on both sides, then a stretch without, then idling again
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_random_traffic(200);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_traffic(60);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_output_backpressure();
      test_drain_pause();
      test_random_traffic(100);

      wait_all_answered();
      repeat (20) @(posedge clock);

      $display("covered %0d command words: %0d read answers and %0d display writes checked",
               words_sent, reads_checked, digits_checked);
      $display("%0d mismatches, %0d answers left over", error_count, pending_answers.size());
      if (error_count == 0 && pending_answers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
sv/lcvfb_pkg.sv
sv/lcvfb_ctrl.sv
sv/lcvfb_dp.sv
sv/led_cube_voxel_frame_buffer_unit.sv
test/tb_top.sv
